FILE: rtl/core/mfd_pkg.sv
`default_nettype none

package mfd_pkg;

   // Longest read, in bytes
   localparam logic [10:0] MAX_BYTES = 11'd1024;

   // Length of the A1 sync mark, in pulses
   localparam logic [3:0] MARK_LEN = 4'd14;

   // Register reset values
   localparam logic [7:0] MEDIUM_MIN_RST = 8'd40;
   localparam logic [7:0] LONG_MIN_RST   = 8'd56;
   localparam logic [7:0] SYNC_RUN_RST   = 8'd80;

   // Bits per byte
   localparam logic [3:0] BYTE_BITS = 4'd8;

   // Request opcodes
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_PULSE   = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_MEDIUM_MIN = 2'd0;
   localparam logic [1:0] CSR_LONG_MIN   = 2'd1;
   localparam logic [1:0] CSR_SYNC_RUN   = 2'd2;

   // Pulse class
   typedef enum logic [1:0] {
      CLS_S,
      CLS_M,
      CLS_L
   } cls_type;

   // Deframer mode
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_HUNT,
      MODE_SKIP,
      MODE_MARK,
      MODE_DATA
   } mode_type;

   // Request beat as seen by the decode stage
   typedef struct packed {
      logic [1:0]  opcode;
      cls_type     cls;
      logic [10:0] byte_count;
   } item_type;

   // Result beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       timed_out;
   } rsp_type;

   // Expected class at each position of the sync mark LMLMS LMLMS LMLM
   function automatic cls_type mark_cls(logic [3:0] idx);
      cls_type c;
      case (idx)
         4'd0, 4'd2, 4'd5, 4'd7, 4'd10, 4'd12: c = CLS_L;
         4'd1, 4'd3, 4'd6, 4'd8, 4'd11, 4'd13: c = CLS_M;
         4'd4, 4'd9:                           c = CLS_S;
         default:                              c = CLS_S;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mfd_classify.sv
`default_nettype none

module mfd_classify (
   input  wire logic [7:0]      interval,
   input  wire logic [7:0]      medium_min,
   input  wire logic [7:0]      long_min,
   output mfd_pkg::cls_type     cls
);
   import mfd_pkg::*;

   // Short test first: with medium_min above long_min there is no medium
   always_comb begin
      if (interval < medium_min) begin
         cls = CLS_S;
      end else if (interval < long_min) begin
         cls = CLS_M;
      end else begin
         cls = CLS_L;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/mfd_core.sv
`default_nettype none

module mfd_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire mfd_pkg::item_type   item,
   input  wire logic [7:0]          sync_run,
   output logic                     emit,
   output mfd_pkg::rsp_type         result
);
   import mfd_pkg::*;

   typedef struct packed {
      logic [7:0]  shift;
      logic [3:0]  bits;
      logic [10:0] bytes;
   } dstate_type;

   typedef struct packed {
      dstate_type  st;
      logic        emit;
      logic        last;
      logic [7:0]  data;
   } push_type;

   // Shift one MFM bit in, MSB first; flag a finished byte
   function automatic push_type push(dstate_type s, logic b);
      push_type   r;
      logic [7:0] sh;
      logic [3:0] bl;
      sh = {s.shift[6:0], b};
      bl = s.bits - 4'd1;
      r.st = s;
      r.st.shift = sh;
      r.st.bits = bl;
      r.emit = 1'b0;
      r.last = 1'b0;
      r.data = sh;
      if (bl == 4'd0) begin
         r.emit = 1'b1;
         r.st.bits = BYTE_BITS;
         r.st.shift = 8'd0;
         if (s.bytes != 11'd0) begin
            r.st.bytes = s.bytes - 11'd1;
         end
         r.last = (r.st.bytes == 11'd0);
      end
      return r;
   endfunction

   mode_type    mode_ff, mode_in;
   logic [7:0]  short_run_left_ff, short_run_left_in;
   logic [3:0]  mark_index_ff, mark_index_in;
   logic        odd_phase_ff, odd_phase_in;
   logic [3:0]  bits_left_ff, bits_left_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [10:0] bytes_left_ff, bytes_left_in;

   logic [7:0]  run_start;
   logic [10:0] count_eff;
   dstate_type  dcur;
   push_type    p1, p2;
   logic        first_bit;
   logic        two_bits;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_IDLE;
         short_run_left_ff <= 8'd0;
         mark_index_ff     <= 4'd0;
         odd_phase_ff      <= 1'b1;
         bits_left_ff      <= BYTE_BITS;
         shift_byte_ff     <= 8'd0;
         bytes_left_ff     <= 11'd0;
      end else if (fire) begin
         mode_ff           <= mode_in;
         short_run_left_ff <= short_run_left_in;
         mark_index_ff     <= mark_index_in;
         odd_phase_ff      <= odd_phase_in;
         bits_left_ff      <= bits_left_in;
         shift_byte_ff     <= shift_byte_in;
         bytes_left_ff     <= bytes_left_in;
      end
   end

   // Clamp the run length and byte count
   assign run_start = (sync_run == 8'd0) ? 8'd1 : sync_run;
   always_comb begin
      if (item.byte_count == 11'd0) begin
         count_eff = 11'd1;
      end else if (item.byte_count > MAX_BYTES) begin
         count_eff = MAX_BYTES;
      end else begin
         count_eff = item.byte_count;
      end
   end

   // Data decode: first bit, then an optional trailing one
   assign dcur      = '{shift: shift_byte_ff, bits: bits_left_ff, bytes: bytes_left_ff};
   assign first_bit = odd_phase_ff && (item.cls == CLS_S);
   assign two_bits  = odd_phase_ff ? (item.cls == CLS_L) : (item.cls != CLS_S);
   assign p1        = push(dcur, first_bit);
   assign p2        = push(p1.st, 1'b1);

   // Next state and result
   always_comb begin
      mode_in           = mode_ff;
      short_run_left_in = short_run_left_ff;
      mark_index_in     = mark_index_ff;
      odd_phase_in      = odd_phase_ff;
      bits_left_in      = bits_left_ff;
      shift_byte_in     = shift_byte_ff;
      bytes_left_in     = bytes_left_ff;
      emit              = 1'b0;
      result            = '{data_byte: 8'd0, last: 1'b0, timed_out: 1'b0};

      case (item.opcode)
         OP_START: begin
            bytes_left_in     = count_eff;
            mark_index_in     = 4'd0;
            odd_phase_in      = 1'b1;
            bits_left_in      = BYTE_BITS;
            shift_byte_in     = 8'd0;
            mode_in           = MODE_HUNT;
            short_run_left_in = run_start;
         end
         OP_TIMEOUT: begin
            if (mode_ff != MODE_IDLE) begin
               mode_in = MODE_IDLE;
               emit    = 1'b1;
               result  = '{data_byte: 8'd0, last: 1'b1, timed_out: 1'b1};
            end
         end
         OP_PULSE: begin
            case (mode_ff)
               MODE_HUNT: begin
                  if (item.cls != CLS_S) begin
                     short_run_left_in = run_start;
                  end else begin
                     short_run_left_in = short_run_left_ff - 8'd1;
                     if (short_run_left_in == 8'd0) begin
                        mode_in = MODE_SKIP;
                     end
                  end
               end
               MODE_SKIP: begin
                  if (item.cls == CLS_M) begin
                     mode_in       = MODE_MARK;
                     mark_index_in = 4'd0;
                  end else if (item.cls == CLS_L) begin
                     mode_in           = MODE_HUNT;
                     short_run_left_in = run_start;
                  end
               end
               MODE_MARK: begin
                  if (mark_index_ff >= MARK_LEN || item.cls != mark_cls(mark_index_ff)) begin
                     mark_index_in     = 4'd0;
                     mode_in           = MODE_HUNT;
                     short_run_left_in = run_start;
                  end else if (mark_index_ff + 4'd1 == MARK_LEN) begin
                     mark_index_in = 4'd0;
                     mode_in       = MODE_DATA;
                     odd_phase_in  = 1'b1;
                     bits_left_in  = BYTE_BITS;
                     shift_byte_in = 8'd0;
                  end else begin
                     mark_index_in = mark_index_ff + 4'd1;
                  end
               end
               MODE_DATA: begin
                  // Phase: odd M goes even, even M or L goes odd
                  if (odd_phase_ff && item.cls == CLS_M) begin
                     odd_phase_in = 1'b0;
                  end else if (!odd_phase_ff && item.cls != CLS_S) begin
                     odd_phase_in = 1'b1;
                  end
                  if (p1.emit && (p1.last || !two_bits)) begin
                     // drop the second bit after the final byte
                     shift_byte_in = p1.st.shift;
                     bits_left_in  = p1.st.bits;
                     bytes_left_in = p1.st.bytes;
                  end else if (two_bits) begin
                     shift_byte_in = p2.st.shift;
                     bits_left_in  = p2.st.bits;
                     bytes_left_in = p2.st.bytes;
                  end else begin
                     shift_byte_in = p1.st.shift;
                     bits_left_in  = p1.st.bits;
                     bytes_left_in = p1.st.bytes;
                  end
                  if (p1.emit) begin
                     emit   = 1'b1;
                     result = '{data_byte: p1.data, last: p1.last, timed_out: 1'b0};
                     if (p1.last) begin
                        mode_in = MODE_IDLE;
                     end
                  end else if (two_bits && p2.emit) begin
                     emit   = 1'b1;
                     result = '{data_byte: p2.data, last: p2.last, timed_out: 1'b0};
                     if (p2.last) begin
                        mode_in = MODE_IDLE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Bit counter stays within one byte
   assert property (@(posedge clock) disable iff (reset)
      bits_left_ff != 4'd0 && bits_left_ff <= BYTE_BITS)
      else $error("mfd_core: bit counter out of range");

   // Mark position never runs past the mark
   assert property (@(posedge clock) disable iff (reset)
      mark_index_ff < MARK_LEN)
      else $error("mfd_core: mark index past end of mark");

   // A start beat never yields a result
   assert property (@(posedge clock) disable iff (reset)
      emit |-> item.opcode != OP_START)
      else $error("mfd_core: result on start beat");

   // A timeout or last byte leaves the block idle
   assert property (@(posedge clock) disable iff (reset)
      fire && emit && result.last |=> mode_ff == MODE_IDLE)
      else $error("mfd_core: not idle after final beat");

   // Data mode always has bytes outstanding
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DATA |-> bytes_left_ff != 11'd0)
      else $error("mfd_core: data mode with no bytes left");

endmodule

`default_nettype wire

FILE: rtl/core/mfm_pulse_deframer_top.sv
// MFM pulse deframer.
// Request channel (req_valid/req_stall): one beat per opcode; start read
// carries req_byte_count, pulse carries req_interval, timeout carries nothing.
// Result channel (rsp_valid/rsp_stall): one beat per decoded byte, or one
// error beat (rsp_timed_out and rsp_last high, zero data) when a timeout ends
// an active read. rsp_last marks the final byte of the requested count.
// Register port (csr_write/csr_index/csr_wdata): medium_min, long_min and
// sync_run thresholds; write only while no beats are in flight.
// Path: an accepted request beat is held in the input register, then decoded
// when it advances, and its result is loaded into the result register that
// drives rsp_valid.
// Throughput: one request beat per cycle while req_stall is low; the decode
// stage updates all state for a beat in a single step.
// Reset clears the thresholds to 40/56/80 and returns the deframer to idle,
// where pulses and timeouts are dropped until a start read arrives.
// When the receiver stalls, the pending result holds in the result register;
// beats that produce no result keep moving, and one more beat is held in the
// input register before req_stall rises.
`default_nettype none

module mfm_pulse_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_interval,
   input  wire logic [10:0] req_byte_count,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_last,
   output logic             rsp_timed_out,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import mfd_pkg::*;

   logic [7:0]  medium_min_ff;
   logic [7:0]  long_min_ff;
   logic [7:0]  sync_run_ff;

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_opcode_ff;
   logic [7:0]  in_interval_ff;
   logic [10:0] in_byte_count_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   cls_type     cls;
   item_type    item;
   logic        emit;
   rsp_type     result;
   logic        req_take;
   logic        advance;

   // Threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         medium_min_ff <= MEDIUM_MIN_RST;
         long_min_ff   <= LONG_MIN_RST;
         sync_run_ff   <= SYNC_RUN_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MEDIUM_MIN: medium_min_ff <= csr_wdata;
            CSR_LONG_MIN:   long_min_ff   <= csr_wdata;
            CSR_SYNC_RUN:   sync_run_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Advance the held beat unless its result would overwrite a stalled one
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall || !emit);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff     <= req_opcode;
         in_interval_ff   <= req_interval;
         in_byte_count_ff <= req_byte_count;
      end
   end

   mfd_classify u_classify (
      .interval   (in_interval_ff),
      .medium_min (medium_min_ff),
      .long_min   (long_min_ff),
      .cls        (cls)
   );

   assign item = '{opcode: in_opcode_ff, cls: cls, byte_count: in_byte_count_ff};

   mfd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (item),
      .sync_run (sync_run_ff),
      .emit     (emit),
      .result   (result)
   );

   // Result register: load a new beat, or drop the one taken
   always_comb begin
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_ff.data_byte;
   assign rsp_last      = rsp_ff.last;
   assign rsp_timed_out = rsp_ff.timed_out;

   // A stalled result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !(advance && emit))
      else $error("mfm_pulse_deframer_top: stalled result overwritten");

   // The held request beat is not replaced while it waits
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_take)
      else $error("mfm_pulse_deframer_top: held request beat replaced");

   // An error beat always closes the read
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_timed_out |-> rsp_last && rsp_data_byte == 8'd0)
      else $error("mfm_pulse_deframer_top: malformed error beat");

endmodule

`default_nettype wire
